FILE: src/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared constants and types for the trapezoid motion profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // intermediate products are capped at 2^CAP_W - 1
    localparam int CAP_W      = 62;
    // multiplier digit consumed per cycle
    localparam int DIGIT_W    = 16;

    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    localparam logic [1:0] REG_ACCEL        = 2'd0;
    localparam logic [1:0] REG_MAX_VELOCITY = 2'd1;
    localparam logic [1:0] REG_DISTANCE     = 2'd2;

    typedef struct packed {
        logic start;
        logic mode;
    } ds_ctrl_t;

endpackage

FILE: src/tmp_mul.sv
// ----------------------------------------------------------------------------
// tmp_mul
// Digit-serial multiplier: wide operand times one DIGIT_W slice per cycle.
// ----------------------------------------------------------------------------
module tmp_mul #(
    parameter int WORD_WIDTH = tmp_pkg::WORD_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [tmp_pkg::CAP_W-1:0]            op_x,
    input  logic [WORD_WIDTH-1:0]                op_y,
    output logic                                 done,
    output logic [tmp_pkg::CAP_W+WORD_WIDTH-1:0] prod
);

    localparam int XW   = tmp_pkg::CAP_W;
    localparam int DW   = tmp_pkg::DIGIT_W;
    localparam int NDIG = (WORD_WIDTH + DW - 1) / DW;
    localparam int YW   = NDIG * DW;
    localparam int PW   = XW + WORD_WIDTH;
    localparam int CW   = $clog2(NDIG + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [PW-1:0] acc_reg;

    logic [XW+DW-1:0] partial;
    logic [PW-1:0]    acc_next;

    // most significant digit first, accumulator shifts up one digit per step
    assign partial  = x_reg * y_reg[YW-1 -: DW];
    assign acc_next = {acc_reg[PW-DW-1:0], {DW{1'b0}}} + PW'(partial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NDIG);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= op_x;
            y_reg   <= YW'(op_y);
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            y_reg   <= y_reg << DW;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: src/tmp_divsqrt.sv
// ----------------------------------------------------------------------------
// tmp_divsqrt
// Shared restoring unit: fixed-point divide (one bit per cycle) or
// square root (one root bit per cycle) over one compare-subtract.
// ----------------------------------------------------------------------------
module tmp_divsqrt #(
    parameter int WORD_WIDTH = tmp_pkg::WORD_WIDTH,
    parameter int FRAC_BITS  = tmp_pkg::FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tmp_pkg::ds_ctrl_t       ctrl,
    input  logic [WORD_WIDTH-1:0]   num,
    input  logic [WORD_WIDTH-1:0]   den,
    output logic                    done,
    output logic [WORD_WIDTH-1:0]   res
);

    localparam int DW = WORD_WIDTH + FRAC_BITS;
    localparam int SH = DW + (DW % 2);
    localparam int NR = SH / 2;
    localparam int RW = (WORD_WIDTH + 1 > NR + 2) ? WORD_WIDTH + 1 : NR + 2;
    localparam int CW = $clog2(SH + 1);
    localparam logic [WORD_WIDTH-1:0] SMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  mode_reg;
    logic [WORD_WIDTH-1:0] den_reg;
    logic [SH-1:0]         sh_reg;
    logic [RW-1:0]         rem_reg;
    logic [SH-1:0]         root_reg;

    logic [RW-1:0] rem_div;
    logic [RW-1:0] rem_sq;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    assign rem_div = {rem_reg[RW-2:0], sh_reg[SH-1]};
    assign rem_sq  = {rem_reg[RW-3:0], sh_reg[SH-1:SH-2]};
    assign rem_sh  = (mode_reg == tmp_pkg::MODE_SQRT) ? rem_sq : rem_div;
    assign trial   = (mode_reg == tmp_pkg::MODE_SQRT) ? {root_reg[RW-3:0], 2'b01}
                                                      : RW'(den_reg);
    assign ge      = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctrl.mode == tmp_pkg::MODE_SQRT) ? CW'(NR) : CW'(SH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mode_reg <= ctrl.mode;
            den_reg  <= den;
            sh_reg   <= SH'({num, {FRAC_BITS{1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[SH-2:0], ge};
            sh_reg   <= (mode_reg == tmp_pkg::MODE_SQRT) ? sh_reg << 2 : sh_reg << 1;
        end
    end

    // quotient saturates; a zero divisor gives all ones and lands here too
    assign res  = (|root_reg[SH-1:WORD_WIDTH-1]) ? SMAX : root_reg[WORD_WIDTH-1:0];
    assign done = done_reg;

endmodule

FILE: src/trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Trapezoid / triangle velocity profile generator in fixed point, built on
// a digit-serial multiplier and a shared divide / square-root unit.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-------------------------------
//   s_       | in        | s_valid / s_ready | restart, time_step
//   m_       | out       | m_valid / m_ready | velocity, displacement, error
//   cfg_     | in        | cfg_wr_en         | cfg_index, cfg_data
//
// A tick with a negative time runs no multiply; the decel segment of a
// trapezoid takes the longest, as it runs the most serial multiplies.
// A restart adds two multiplies plus two divides, or one divide and one root.
// One item is worked on at a time; s_ready is high only while idle.
// A held result in the output register does not block the next transfer in.
// Reset is synchronous: config returns to accel = max_velocity = 1.0.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile #(
    parameter int WORD_WIDTH = tmp_pkg::WORD_WIDTH,
    parameter int FRAC_BITS  = tmp_pkg::FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [WORD_WIDTH-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    input  logic signed [WORD_WIDTH-1:0]  s_time_step,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [WORD_WIDTH-1:0]  m_velocity,
    output logic signed [WORD_WIDTH-1:0]  m_displacement,
    output logic                          m_time_error
);

    localparam int W  = WORD_WIDTH;
    localparam int XW = tmp_pkg::CAP_W;
    localparam int PW = XW + W;

    localparam logic [W-1:0]  ONE_Q   = W'(1) << FRAC_BITS;
    localparam logic [W-1:0]  NEG_ONE = ~ONE_Q + 1'b1;
    localparam logic [W-1:0]  SMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [XW-1:0] CAP     = {XW{1'b1}};

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PLAN_VV = 4'd1;
    localparam logic [3:0] ST_PLAN_AD = 4'd2;
    localparam logic [3:0] ST_DIV_TB  = 4'd3;
    localparam logic [3:0] ST_DIV_TF  = 4'd4;
    localparam logic [3:0] ST_SQRT    = 4'd5;
    localparam logic [3:0] ST_VEL     = 4'd6;
    localparam logic [3:0] ST_XA      = 4'd7;
    localparam logic [3:0] ST_AB      = 4'd8;
    localparam logic [3:0] ST_XD      = 4'd9;
    localparam logic [3:0] ST_H       = 4'd10;
    localparam logic [3:0] ST_XB      = 4'd11;
    localparam logic [3:0] ST_XC1     = 4'd12;
    localparam logic [3:0] ST_AU      = 4'd13;
    localparam logic [3:0] ST_XC2     = 4'd14;
    localparam logic [3:0] ST_DONE    = 4'd15;

    localparam logic [1:0] SEG_ACCEL  = 2'd0;
    localparam logic [1:0] SEG_CRUISE = 2'd1;
    localparam logic [1:0] SEG_DECEL  = 2'd2;
    localparam logic [1:0] SEG_STOP   = 2'd3;

    // configuration and profile state
    logic [W-1:0] accel_reg, accel_next;
    logic [W-1:0] vmax_reg, vmax_next;
    logic [W-1:0] dist_reg, dist_next;
    logic [W-1:0] elapsed_reg, elapsed_next;
    logic [W-1:0] blend_reg, blend_next;
    logic [W-1:0] final_reg, final_next;
    logic         cruise_reg, cruise_next;

    // sequencer
    logic [3:0]   state_reg, state_next;
    logic         mul_issued_reg, mul_issued_next;
    logic         ds_issued_reg, ds_issued_next;
    logic         err_reg, err_next;
    logic [W-1:0] step_reg, step_next;

    // work registers
    logic [PW-1:0] pv_reg, pv_next;
    logic [XW-1:0] vel_reg, vel_next;
    logic [XW-1:0] disp_reg, disp_next;
    logic [XW-1:0] ab_reg, ab_next;
    logic [XW-1:0] tmp_reg, tmp_next;

    // result register
    logic         m_valid_reg, m_valid_next;
    logic [W-1:0] m_vel_reg, m_vel_next;
    logic [W-1:0] m_disp_reg, m_disp_next;
    logic         m_err_reg, m_err_next;

    // shared units
    logic          mul_need;
    logic          mul_start;
    logic [XW-1:0] mul_x;
    logic [W-1:0]  mul_y;
    logic          mul_done;
    logic [PW-1:0] mul_prod;

    tmp_pkg::ds_ctrl_t ds_ctrl;
    logic          ds_need;
    logic [W-1:0]  ds_num;
    logic [W-1:0]  ds_den;
    logic          ds_done;
    logic [W-1:0]  ds_res;

    // datapath helpers
    logic [W-1:0]          dabs;
    logic [W-1:0]          tf_tb;
    logic [W-1:0]          u_off;
    logic [W-1:0]          w_off;
    logic [W-1:0]          cruise_len;
    logic [1:0]            seg;
    logic                  t_neg;
    logic [PW-FRAC_BITS-1:0] prod_shr;
    logic [XW-1:0]         umul_res;
    logic [XW:0]           add_sum;
    logic [XW-1:0]         uadd_res;
    logic [W:0]            tf_sum;
    logic [W:0]            t_sum;

    tmp_mul #(
        .WORD_WIDTH (W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_x    (mul_x),
        .op_y    (mul_y),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    tmp_divsqrt #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ds_ctrl),
        .num     (ds_num),
        .den     (ds_den),
        .done    (ds_done),
        .res     (ds_res)
    );

    // divisor: accel for the blend time, max velocity for the final time
    assign ds_den = (state_reg == ST_DIV_TF) ? vmax_reg : accel_reg;

    assign dabs       = dist_reg[W-1] ? (~dist_reg + 1'b1) : dist_reg;
    assign tf_tb      = final_reg - blend_reg;
    assign u_off      = elapsed_reg - tf_tb;
    assign w_off      = elapsed_reg - blend_reg;
    assign cruise_len = (tf_tb >= blend_reg) ? tf_tb - blend_reg : '0;
    assign t_neg      = elapsed_reg[W-1];

    always_comb begin
        if (elapsed_reg < blend_reg) begin
            seg = SEG_ACCEL;
        end else if (cruise_reg && elapsed_reg < tf_tb) begin
            seg = SEG_CRUISE;
        end else if (elapsed_reg < final_reg) begin
            seg = SEG_DECEL;
        end else begin
            seg = SEG_STOP;
        end
    end

    // product scaled back to Q format and capped
    assign prod_shr = mul_prod[PW-1:FRAC_BITS];
    assign umul_res = (|prod_shr[PW-FRAC_BITS-1:XW]) ? CAP : prod_shr[XW-1:0];
    assign add_sum  = {1'b0, disp_reg} + {1'b0, umul_res};
    assign uadd_res = add_sum[XW] ? CAP : add_sum[XW-1:0];
    assign tf_sum   = {1'b0, blend_reg} + {1'b0, ds_res};
    assign t_sum    = {elapsed_reg[W-1], elapsed_reg} + {step_reg[W-1], step_reg};

    // operand select for the multiplier
    always_comb begin
        mul_need = 1'b1;
        mul_x    = '0;
        mul_y    = '0;
        case (state_reg)
            ST_PLAN_VV: begin
                mul_x = XW'(vmax_reg);
                mul_y = vmax_reg;
            end
            ST_PLAN_AD: begin
                mul_x = XW'(accel_reg);
                mul_y = dabs;
            end
            ST_VEL: begin
                mul_need = !t_neg && (seg == SEG_ACCEL || seg == SEG_DECEL);
                mul_x    = XW'(accel_reg);
                mul_y    = (seg == SEG_ACCEL) ? elapsed_reg : final_reg - elapsed_reg;
            end
            ST_XA: begin
                mul_x = vel_reg;
                mul_y = elapsed_reg;
            end
            ST_AB: begin
                mul_x = XW'(accel_reg);
                mul_y = blend_reg;
            end
            ST_XD: begin
                mul_x = ab_reg;
                mul_y = cruise_reg ? tf_tb : blend_reg;
            end
            ST_H: begin
                mul_x = ab_reg;
                mul_y = blend_reg;
            end
            ST_XB: begin
                mul_x = XW'(vmax_reg);
                mul_y = w_off;
            end
            ST_XC1: begin
                mul_x = XW'(vmax_reg);
                mul_y = cruise_len;
            end
            ST_AU: begin
                mul_x = XW'(accel_reg);
                mul_y = cruise_reg ? u_off : w_off;
            end
            ST_XC2: begin
                mul_x = tmp_reg;
                mul_y = cruise_reg ? blend_reg - (u_off >> 1)
                                   : tf_tb - (w_off >> 1);
            end
            default: begin
                mul_need = 1'b0;
            end
        endcase
    end

    assign mul_start = mul_need && !mul_issued_reg;

    always_comb begin
        ds_need      = 1'b1;
        ds_ctrl.mode = tmp_pkg::MODE_DIV;
        ds_num       = '0;
        case (state_reg)
            ST_DIV_TB: ds_num = cruise_reg ? vmax_reg : dabs;
            ST_DIV_TF: ds_num = dabs;
            ST_SQRT: begin
                ds_ctrl.mode = tmp_pkg::MODE_SQRT;
                ds_num       = blend_reg;
            end
            default: ds_need = 1'b0;
        endcase
        ds_ctrl.start = ds_need && !ds_issued_reg;
    end

    always_comb begin
        accel_next      = accel_reg;
        vmax_next       = vmax_reg;
        dist_next       = dist_reg;
        elapsed_next    = elapsed_reg;
        blend_next      = blend_reg;
        final_next      = final_reg;
        cruise_next     = cruise_reg;
        state_next      = state_reg;
        mul_issued_next = mul_issued_reg;
        ds_issued_next  = ds_issued_reg;
        err_next        = err_reg;
        step_next       = step_reg;
        pv_next         = pv_reg;
        vel_next        = vel_reg;
        disp_next       = disp_reg;
        ab_next         = ab_reg;
        tmp_next        = tmp_reg;
        m_valid_next    = m_valid_reg;
        m_vel_next      = m_vel_reg;
        m_disp_next     = m_disp_reg;
        m_err_next      = m_err_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                tmp_pkg::REG_ACCEL:        accel_next = cfg_data;
                tmp_pkg::REG_MAX_VELOCITY: vmax_next  = cfg_data;
                tmp_pkg::REG_DISTANCE:     dist_next  = cfg_data;
                default: ;
            endcase
        end

        if (mul_start) begin
            mul_issued_next = 1'b1;
        end
        if (mul_done) begin
            mul_issued_next = 1'b0;
        end
        if (ds_ctrl.start) begin
            ds_issued_next = 1'b1;
        end
        if (ds_done) begin
            ds_issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    step_next  = s_time_step;
                    err_next   = 1'b0;
                    state_next = s_restart ? ST_PLAN_VV : ST_VEL;
                end
            end
            ST_PLAN_VV: begin
                if (mul_done) begin
                    pv_next    = mul_prod;
                    state_next = ST_PLAN_AD;
                end
            end
            ST_PLAN_AD: begin
                if (mul_done) begin
                    cruise_next = pv_reg < mul_prod;
                    state_next  = ST_DIV_TB;
                end
            end
            ST_DIV_TB: begin
                // triangle case parks d/a in blend until the root is taken
                if (ds_done) begin
                    blend_next = ds_res;
                    state_next = cruise_reg ? ST_DIV_TF : ST_SQRT;
                end
            end
            ST_DIV_TF: begin
                if (ds_done) begin
                    final_next   = (|tf_sum[W:W-1]) ? SMAX : tf_sum[W-1:0];
                    elapsed_next = '0;
                    state_next   = ST_VEL;
                end
            end
            ST_SQRT: begin
                if (ds_done) begin
                    blend_next   = ds_res;
                    final_next   = (|ds_res[W-1:W-2]) ? SMAX : {ds_res[W-2:0], 1'b0};
                    elapsed_next = '0;
                    state_next   = ST_VEL;
                end
            end
            ST_VEL: begin
                if (t_neg) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (seg == SEG_CRUISE) begin
                    vel_next   = XW'(vmax_reg);
                    state_next = ST_AB;
                end else if (seg == SEG_STOP) begin
                    vel_next   = '0;
                    state_next = ST_AB;
                end else if (mul_done) begin
                    vel_next   = umul_res;
                    state_next = (seg == SEG_ACCEL) ? ST_XA : ST_AB;
                end
            end
            ST_XA: begin
                if (mul_done) begin
                    disp_next  = umul_res >> 1;
                    state_next = ST_DONE;
                end
            end
            ST_AB: begin
                if (mul_done) begin
                    ab_next    = umul_res;
                    state_next = (seg == SEG_STOP) ? ST_XD : ST_H;
                end
            end
            ST_XD: begin
                if (mul_done) begin
                    disp_next  = umul_res;
                    state_next = ST_DONE;
                end
            end
            ST_H: begin
                if (mul_done) begin
                    disp_next = umul_res >> 1;
                    if (seg == SEG_CRUISE) begin
                        state_next = ST_XB;
                    end else begin
                        state_next = cruise_reg ? ST_XC1 : ST_AU;
                    end
                end
            end
            ST_XB: begin
                if (mul_done) begin
                    disp_next  = uadd_res;
                    state_next = ST_DONE;
                end
            end
            ST_XC1: begin
                if (mul_done) begin
                    disp_next  = uadd_res;
                    state_next = ST_AU;
                end
            end
            ST_AU: begin
                if (mul_done) begin
                    tmp_next   = umul_res;
                    state_next = ST_XC2;
                end
            end
            ST_XC2: begin
                if (mul_done) begin
                    disp_next  = uadd_res;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_err_next   = err_reg;
                    if (err_reg) begin
                        m_vel_next   = NEG_ONE;
                        m_disp_next  = NEG_ONE;
                        elapsed_next = '0;
                    end else begin
                        m_vel_next   = (|vel_reg[XW-1:W-1]) ? SMAX : vel_reg[W-1:0];
                        m_disp_next  = (|disp_reg[XW-1:W-1]) ? SMAX : disp_reg[W-1:0];
                        elapsed_next = (!t_sum[W] && t_sum[W-1]) ? SMAX : t_sum[W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg      <= ONE_Q;
            vmax_reg       <= ONE_Q;
            dist_reg       <= '0;
            elapsed_reg    <= '0;
            blend_reg      <= '0;
            final_reg      <= '0;
            cruise_reg     <= 1'b0;
            state_reg      <= ST_IDLE;
            mul_issued_reg <= 1'b0;
            ds_issued_reg  <= 1'b0;
            err_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            accel_reg      <= accel_next;
            vmax_reg       <= vmax_next;
            dist_reg       <= dist_next;
            elapsed_reg    <= elapsed_next;
            blend_reg      <= blend_next;
            final_reg      <= final_next;
            cruise_reg     <= cruise_next;
            state_reg      <= state_next;
            mul_issued_reg <= mul_issued_next;
            ds_issued_reg  <= ds_issued_next;
            err_reg        <= err_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        pv_reg     <= pv_next;
        vel_reg    <= vel_next;
        disp_reg   <= disp_next;
        ab_reg     <= ab_next;
        tmp_reg    <= tmp_next;
        m_vel_reg  <= m_vel_next;
        m_disp_reg <= m_disp_next;
        m_err_reg  <= m_err_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_velocity     = m_vel_reg;
    assign m_displacement = m_disp_reg;
    assign m_time_error   = m_err_reg;

    // no unit is left running once the sequencer is back to idle
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !mul_issued_reg && !ds_issued_reg)
        else $error("shared unit still busy while idle");

    a_mul_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> mul_issued_reg)
        else $error("multiplier finished without a request");

    a_plan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_VEL |-> final_reg >= blend_reg)
        else $error("final time below blend time");

    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg |-> m_vel_reg == NEG_ONE && m_disp_reg == NEG_ONE)
        else $error("time error result is not minus one");

endmodule

FILE: dv/tb_trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// tb_trapezoid_motion_profile
// Self-checking bench: plans trapezoid / triangle profiles in a local
// predictor, drives random restarts and time steps under bursty input and
// stalling output, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_trapezoid_motion_profile;

    localparam int W = 32;
    localparam int F = 16;
    localparam longint unsigned SMAXV = 64'h7fff_ffff;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [W-1:0] vel;
        logic [W-1:0] disp;
        logic         err;
    } motion_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_index = tmp_pkg::REG_ACCEL;
    logic [W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_restart = 0;
    logic signed [W-1:0] s_time_step = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [W-1:0] m_velocity, m_displacement;
    logic m_time_error;

    trapezoid_motion_profile dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // predictor state
    logic [W-1:0] p_accel, p_vmax;
    logic signed [W-1:0] p_dist;
    longint p_elapsed;
    logic [127:0] CAPV = (128'd1 << 62) - 1;
    longint unsigned p_blend, p_final;
    bit p_cruise;

    motion_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 0;
    int stall_mode = 0;

    function automatic longint unsigned fx_mul(longint unsigned x, longint unsigned y);
        logic [127:0] p;
        p = ({64'd0, x} * {64'd0, y}) >> F;
        return (p > CAPV) ? CAPV[63:0] : p[63:0];
    endfunction

    function automatic longint unsigned fx_add(longint unsigned x, longint unsigned y);
        logic [127:0] s;
        s = {64'd0, x} + {64'd0, y};
        return (s > CAPV) ? CAPV[63:0] : s[63:0];
    endfunction

    function automatic longint unsigned fx_div(longint unsigned n, longint unsigned d);
        logic [127:0] q;
        if (d == 0) return SMAXV;
        q = ({64'd0, n} << F) / {64'd0, d};
        return (q > SMAXV) ? SMAXV : q[63:0];
    endfunction

    function automatic longint unsigned fx_sqrt(longint unsigned q);
        logic [127:0] x;
        logic [127:0] t;
        longint unsigned r;
        x = {64'd0, q} << F;
        r = 0;
        for (int b = 47; b >= 0; b--) begin
            t = {64'd0, r | (64'd1 << b)};
            if (t * t <= x) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic longint unsigned clip_out(longint unsigned x);
        return (x > SMAXV) ? SMAXV : x;
    endfunction

    function automatic void plan_profile();
        longint unsigned a, vm, d;
        a = p_accel;
        vm = p_vmax;
        d = (p_dist < 0) ? longint'(-longint'(p_dist)) : longint'(p_dist);
        if ({64'd0, vm} * {64'd0, vm} < {64'd0, a} * {64'd0, d}) begin
            p_cruise = 1;
            p_blend = fx_div(vm, a);
            p_final = clip_out(p_blend + fx_div(d, vm));
        end else begin
            p_cruise = 0;
            p_blend = fx_sqrt(fx_div(d, a));
            p_final = clip_out(2 * p_blend);
        end
        p_elapsed = 0;
    endfunction

    function automatic motion_t profile_tick(bit restart, logic signed [W-1:0] dt);
        motion_t r;
        longint unsigned a, vm, tb, tf, t, v, x, half_atb2, u, w, cruise;
        longint nt;
        a = p_accel;
        vm = p_vmax;
        if (restart) plan_profile();
        if (p_elapsed < 0) begin
            p_elapsed = 0;
            r.vel = -(1 << F);
            r.disp = -(1 << F);
            r.err = 1;
            return r;
        end
        tb = p_blend;
        tf = p_final;
        t = p_elapsed;
        half_atb2 = fx_mul(fx_mul(a, tb), tb) >> 1;
        if (t < tb) begin
            v = fx_mul(a, t);
            x = fx_mul(fx_mul(a, t), t) >> 1;
        end else if (p_cruise && t < tf - tb) begin
            v = vm;
            x = fx_add(half_atb2, fx_mul(vm, t - tb));
        end else if (t < tf) begin
            v = fx_mul(a, tf - t);
            if (p_cruise) begin
                u = t - (tf - tb);
                cruise = (tf - tb >= tb) ? tf - tb - tb : 0;
                x = fx_add(fx_add(half_atb2, fx_mul(vm, cruise)),
                           fx_mul(fx_mul(a, u), tb - (u >> 1)));
            end else begin
                w = t - tb;
                x = fx_add(half_atb2, fx_mul(fx_mul(a, w), tf - tb - (w >> 1)));
            end
        end else begin
            v = 0;
            x = p_cruise ? fx_mul(fx_mul(a, tb), tf - tb) : fx_mul(fx_mul(a, tb), tb);
        end
        nt = p_elapsed + longint'(dt);
        if (nt > longint'(SMAXV)) nt = SMAXV;
        p_elapsed = nt;
        r.vel = clip_out(v);
        r.disp = clip_out(x);
        r.err = 0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        motion_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_velocity, '0);
            end else begin
                e = expected_q.pop_front();
                if (m_velocity !== e.vel) report_mismatch("velocity", m_velocity, e.vel);
                if (m_displacement !== e.disp)
                    report_mismatch("displacement", m_displacement, e.disp);
                if (m_time_error !== e.err)
                    report_mismatch("time_error", m_time_error, e.err);
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 0;
        else case (stall_mode)
            0: m_ready <= 1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (cycles % 7 < 3);
        endcase
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("trapezoid_motion_profile regression: fail");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_tick(bit restart, logic [W-1:0] dt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
        burst_left--;
        // step past the edge where the previous transfer dropped valid
        @(posedge aclk);
        s_valid <= 1;
        s_restart <= restart;
        s_time_step <= dt;
        do @(posedge aclk); while (!(s_valid && s_ready));
        expected_q.push_back(profile_tick(restart, dt));
        s_valid <= 0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            tmp_pkg::REG_ACCEL:        p_accel = val;
            tmp_pkg::REG_MAX_VELOCITY: p_vmax = val;
            default:                   p_dist = val;
        endcase
    endtask

    task automatic set_profile(logic [W-1:0] a, logic [W-1:0] vm, logic [W-1:0] d);
        drain();
        write_reg(tmp_pkg::REG_ACCEL, a);
        write_reg(tmp_pkg::REG_MAX_VELOCITY, vm);
        write_reg(tmp_pkg::REG_DISTANCE, d);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [W-1:0] rand_small_step();
        return $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4_0000);
    endfunction

    task automatic test_reset_state();
        send_tick(0, 32'h0001_0000);
        send_tick(0, 32'h8000_0000);
        send_tick(0, 32'h0000_0000);
        send_tick(0, 32'hffff_ffff);
    endtask

    task automatic test_directed();
        // trapezoid, triangle, zero divisors, extremes
        set_profile(32'h0002_0000, 32'h0001_0000, 32'h000a_0000);
        send_tick(1, 32'h0000_8000);
        repeat (14) send_tick(0, 32'h0000_8000);
        set_profile(32'h0001_0000, 32'h0010_0000, 32'hfffc_0000);
        send_tick(1, 32'h0001_0000);
        send_tick(0, 32'h7fff_ffff);
        send_tick(0, 32'h7fff_ffff);
        set_profile(32'h0, 32'h0, 32'h8000_0000);
        send_tick(1, 32'h0001_0000);
        set_profile(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        send_tick(1, 32'h0000_0001);
        send_tick(0, 32'h0000_0000);
        send_tick(0, 32'hffff_0000);
    endtask

    task automatic test_random_profiles();
        for (int ph = 0; ph < 12; ph++) begin
            stall_mode = ph % 3;
            set_profile($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, 32'h8_0000),
                        $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, 32'h8_0000),
                        $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 32'h40_0000)
                        * ($urandom_range(0, 1) ? 1 : -1));
            for (int i = 0; i < 60; i++)
                send_tick(i == 0 || $urandom_range(0, 30) == 0,
                          $urandom_range(0, 20) == 0 ? -$urandom_range(1, 32'h2_0000)
                                                     : rand_small_step());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_tick(i == 0, rand_small_step());
            end
            begin
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
        join
        drain();
    endtask

    initial begin
        p_accel = 32'h0001_0000;
        p_vmax = 32'h0001_0000;
        p_dist = 0;
        p_elapsed = 0;
        p_blend = 0;
        p_final = 0;
        p_cruise = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_reset_state();
        test_directed();
        test_backpressure();
        test_random_profiles();
        drain();
        if (errors == 0) $display("trapezoid_motion_profile regression: pass");
        else $display("trapezoid_motion_profile regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
src/tmp_pkg.sv
src/tmp_mul.sv
src/tmp_divsqrt.sv
src/trapezoid_motion_profile.sv
dv/tb_trapezoid_motion_profile.sv
